// ===== sv/lrs_pkg.sv =====
`timescale 1ns / 1ps

package lrs_pkg;

  // Supervisor states; codes match the status field
  typedef enum logic [2:0] {
    ST_DISCONNECTED = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_RECONNECTING = 3'd2,
    ST_CONNECTED    = 3'd3,
    ST_FAILED       = 3'd4
  } link_state_t;

  // Error codes
  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_CONNECT_EXH    = 2'd1;
  localparam logic [1:0] ERR_RECONNECT_EXH  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILED_BACKOFF = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd10000;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd5;
  localparam logic [31:0] FAILED_BACKOFF_RST = 32'd60000;

  localparam logic [7:0] RETRY_CNT_MAX = 8'd255;

  // Poll beat
  typedef struct packed {
    logic        link_up;
    logic [31:0] now_ms;
  } poll_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        start_connect;
    logic        drop_link;
    logic [7:0]  retry_count;
    logic [31:0] reconnect_count;
    logic [1:0]  error_code;
    logic        connected;
  } report_t;

endpackage

// ===== sv/link_retry_supervisor.sv =====
`timescale 1ns / 1ps

// Channel  | handshake            | beat
// ---------+----------------------+-------------------------------------------
// poll     | in_valid / in_ready  | in_data  (poll_t: link_up, now_ms)
// report   | out_valid / out_ready| out_data (report_t: status .. connected)
// config   | cfg_we               | cfg_index, cfg_wdata (no wait, no read-back)
//
// One poll per cycle while in_ready is high; its report appears in the output register the next cycle.
// The state update is one 32-bit subtract and compare plus a small state step.
// in_ready is high while the output register is empty or being drained, so a
// stall on the report side holds off polls only when a report is waiting.
// rst (synchronous) returns state, counters and config to their defaults.

module link_retry_supervisor
  import lrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  poll_t                in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output report_t              out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration
  logic [31:0] retry_interval_ms;
  logic [7:0]  max_retries;
  logic [31:0] failed_backoff_ms;

  // Supervisor state
  link_state_t state, state_next;
  logic [7:0]  retries, retries_next;
  logic [31:0] last_attempt, last_attempt_next;
  logic [31:0] lost_count, lost_count_next;
  logic [1:0]  last_error, last_error_next;
  logic        start_next, drop_next;

  logic        accept;
  logic [31:0] elapsed;
  logic [7:0]  retries_inc;
  report_t     report_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Modular time since the last attempt, saturating retry increment
  assign elapsed     = in_data.now_ms - last_attempt;
  assign retries_inc = (retries == RETRY_CNT_MAX) ? retries : retries + 8'd1;

  // Config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval_ms <= RETRY_INTERVAL_RST;
      max_retries       <= MAX_RETRIES_RST;
      failed_backoff_ms <= FAILED_BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_INTERVAL: retry_interval_ms <= cfg_wdata;
        CFG_MAX_RETRIES:    max_retries       <= cfg_wdata[7:0];
        CFG_FAILED_BACKOFF: failed_backoff_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state and counters
  always_comb begin
    state_next        = state;
    retries_next      = retries;
    last_attempt_next = last_attempt;
    lost_count_next   = lost_count;
    last_error_next   = last_error;
    start_next        = 1'b0;
    drop_next         = 1'b0;
    if (in_data.link_up) begin
      if (state != ST_CONNECTED) begin
        state_next      = ST_CONNECTED;
        retries_next    = '0;
        last_error_next = ERR_NONE;
      end
    end else begin
      unique case (state) inside
        ST_CONNECTING, ST_RECONNECTING: begin
          if (elapsed >= retry_interval_ms) begin
            retries_next = retries_inc;
            if (retries_inc >= max_retries) begin
              last_error_next = (state == ST_CONNECTING) ? ERR_CONNECT_EXH
                                                         : ERR_RECONNECT_EXH;
              state_next      = ST_FAILED;
            end else begin
              start_next        = 1'b1;
              drop_next         = 1'b1;
              state_next        = ST_RECONNECTING;
              last_attempt_next = in_data.now_ms;
            end
          end
        end
        ST_FAILED: begin
          if (elapsed >= failed_backoff_ms) begin
            state_next        = ST_DISCONNECTED;
            retries_next      = '0;
            last_attempt_next = in_data.now_ms;
          end
        end
        ST_CONNECTED: begin
          lost_count_next   = lost_count + 32'd1;
          state_next        = ST_DISCONNECTED;
          retries_next      = '0;
          last_attempt_next = in_data.now_ms;
        end
        // disconnected, and any unused code
        default: begin
          start_next        = 1'b1;
          state_next        = ST_CONNECTING;
          last_attempt_next = in_data.now_ms;
        end
      endcase
    end
  end

  // Report for this poll
  always_comb begin
    report_next.status          = state_next;
    report_next.start_connect   = start_next;
    report_next.drop_link       = drop_next;
    report_next.retry_count     = retries_next;
    report_next.reconnect_count = lost_count_next;
    report_next.error_code      = last_error_next;
    report_next.connected       = in_data.link_up && (state_next == ST_CONNECTED);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_DISCONNECTED;
      retries      <= '0;
      last_attempt <= '0;
      lost_count   <= '0;
      last_error   <= ERR_NONE;
    end else if (accept) begin
      state        <= state_next;
      retries      <= retries_next;
      last_attempt <= last_attempt_next;
      lost_count   <= lost_count_next;
      last_error   <= last_error_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= report_next;
    end
  end

endmodule
